// ----- hdl/utrf_pkg.sv -----
// ----------------------------------------------------------------------------
// utrf_pkg
// Shared sizes, operation codes and stage types of the serial ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package utrf_pkg;

    localparam int TX_DEPTH = 256;
    localparam int RX_DEPTH = 256;

    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_FW = $clog2(TX_DEPTH + 1);
    localparam int RX_FW = $clog2(RX_DEPTH + 1);

    localparam int MODE_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int LEVEL_W = 9;
    localparam int OUT_W   = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_TX    = 3'd0,
        MODE_POP_RX     = 3'd1,
        MODE_LINE_IN    = 3'd2,
        MODE_TX_EMPTY   = 3'd3,
        MODE_TX_DONE    = 3'd4,
        MODE_CLEAR_TX   = 3'd5,
        MODE_CLEAR_RX   = 3'd6,
        MODE_NOP        = 3'd7
    } t_mode;

    typedef struct packed {
        logic ok;
        logic use_tx;
        logic use_rx;
        logic line_valid;
        logic overwrote;
    } t_stage;

endpackage

`default_nettype wire

// ----- hdl/uart_tx_rx_ring_fifo.sv -----
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_fifo
// A request's result passes through a stage register, which takes the ring
// memory read, and then into the output register. No new request is accepted
// while one sits in the stage register or an output result waits to be taken.
// Reset clears indices, fill counts, arm bits and the sending flag at once;
// the ring memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_tx_rx_ring_fifo (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // data[7:0]
    input  wire logic [2:0]  i_s_tuser,   // mode[2:0]
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // ok[0], data_out[8:1], line_byte_valid[9], tx_idle[10], tx_level[19:11],
    // rx_level[28:20], empty_event_armed[29], complete_event_armed[30],
    // rx_overwrote[31]
    output logic [31:0]      o_m_tdata
);

    logic [utrf_pkg::BYTE_W-1:0] r_tx_mem [utrf_pkg::TX_DEPTH];
    logic [utrf_pkg::BYTE_W-1:0] r_rx_mem [utrf_pkg::RX_DEPTH];

    logic [utrf_pkg::TX_AW-1:0]  r_tx_wr, n_tx_wr, r_tx_rd, n_tx_rd;
    logic [utrf_pkg::RX_AW-1:0]  r_rx_wr, n_rx_wr, r_rx_rd, n_rx_rd;
    logic [utrf_pkg::TX_FW-1:0]  r_tx_fill, n_tx_fill;
    logic [utrf_pkg::RX_FW-1:0]  r_rx_fill, n_rx_fill;
    logic                        r_empty_armed, n_empty_armed;
    logic                        r_done_armed, n_done_armed;
    logic                        r_sending, n_sending;

    logic                        r_s1_valid;
    utrf_pkg::t_stage            r_s1, n_s1;
    logic [utrf_pkg::BYTE_W-1:0] r_tx_q, r_rx_q;

    logic                        r_m_valid;
    logic [utrf_pkg::OUT_W-1:0]  r_m_tdata, n_m_tdata;

    logic                        s_accept;
    logic                        tx_we, rx_we;
    utrf_pkg::t_mode             mode;
    logic                        tx_full, tx_empty, rx_full, rx_empty;
    logic [utrf_pkg::TX_AW-1:0]  tx_wr_next, tx_rd_next;
    logic [utrf_pkg::RX_AW-1:0]  rx_wr_next, rx_rd_next;
    logic [utrf_pkg::BYTE_W-1:0] dout;

    assign o_s_tready = !r_s1_valid && (!r_m_valid || i_m_tready);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign mode       = utrf_pkg::t_mode'(i_s_tuser);

    assign tx_full  = (r_tx_fill == utrf_pkg::TX_FW'(utrf_pkg::TX_DEPTH));
    assign tx_empty = (r_tx_fill == '0);
    assign rx_full  = (r_rx_fill == utrf_pkg::RX_FW'(utrf_pkg::RX_DEPTH));
    assign rx_empty = (r_rx_fill == '0);

    assign tx_wr_next = (r_tx_wr == utrf_pkg::TX_AW'(utrf_pkg::TX_DEPTH - 1)) ?
                        '0 : r_tx_wr + 1'b1;
    assign tx_rd_next = (r_tx_rd == utrf_pkg::TX_AW'(utrf_pkg::TX_DEPTH - 1)) ?
                        '0 : r_tx_rd + 1'b1;
    assign rx_wr_next = (r_rx_wr == utrf_pkg::RX_AW'(utrf_pkg::RX_DEPTH - 1)) ?
                        '0 : r_rx_wr + 1'b1;
    assign rx_rd_next = (r_rx_rd == utrf_pkg::RX_AW'(utrf_pkg::RX_DEPTH - 1)) ?
                        '0 : r_rx_rd + 1'b1;

    always_comb begin
        n_tx_wr       = r_tx_wr;
        n_tx_rd       = r_tx_rd;
        n_tx_fill     = r_tx_fill;
        n_rx_wr       = r_rx_wr;
        n_rx_rd       = r_rx_rd;
        n_rx_fill     = r_rx_fill;
        n_empty_armed = r_empty_armed;
        n_done_armed  = r_done_armed;
        n_sending     = r_sending;
        n_s1          = '0;
        tx_we         = 1'b0;
        rx_we         = 1'b0;
        unique case (mode)
            utrf_pkg::MODE_PUSH_TX: begin
                if (!tx_full) begin
                    tx_we     = 1'b1;
                    n_tx_wr   = tx_wr_next;
                    n_tx_fill = r_tx_fill + 1'b1;
                    n_s1.ok   = 1'b1;
                    if (i_s_tlast) begin
                        n_empty_armed = 1'b1;
                    end
                end else begin
                    n_empty_armed = 1'b1;
                end
            end
            utrf_pkg::MODE_POP_RX: begin
                if (!rx_empty) begin
                    n_rx_rd     = rx_rd_next;
                    n_rx_fill   = r_rx_fill - 1'b1;
                    n_s1.ok     = 1'b1;
                    n_s1.use_rx = 1'b1;
                end
            end
            utrf_pkg::MODE_LINE_IN: begin
                rx_we   = 1'b1;
                n_rx_wr = rx_wr_next;
                if (!rx_full) begin
                    n_rx_fill = r_rx_fill + 1'b1;
                end else begin
                    n_s1.overwrote = 1'b1;
                end
            end
            utrf_pkg::MODE_TX_EMPTY: begin
                if (r_empty_armed) begin
                    if (tx_empty) begin
                        n_empty_armed = 1'b0;
                        n_done_armed  = 1'b1;
                    end else begin
                        n_sending       = 1'b1;
                        n_tx_rd         = tx_rd_next;
                        n_tx_fill       = r_tx_fill - 1'b1;
                        n_s1.use_tx     = 1'b1;
                        n_s1.line_valid = 1'b1;
                    end
                end
            end
            utrf_pkg::MODE_TX_DONE: begin
                if (r_done_armed) begin
                    if (tx_empty) begin
                        n_done_armed = 1'b0;
                        n_sending    = 1'b0;
                    end else begin
                        n_tx_rd         = tx_rd_next;
                        n_tx_fill       = r_tx_fill - 1'b1;
                        n_s1.use_tx     = 1'b1;
                        n_s1.line_valid = 1'b1;
                    end
                end
            end
            utrf_pkg::MODE_CLEAR_TX: begin
                n_tx_wr   = '0;
                n_tx_rd   = '0;
                n_tx_fill = '0;
            end
            utrf_pkg::MODE_CLEAR_RX: begin
                n_rx_wr   = '0;
                n_rx_rd   = '0;
                n_rx_fill = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && tx_we) begin
            r_tx_mem[r_tx_wr] <= i_s_tdata;
        end
        if (s_accept) begin
            r_tx_q <= r_tx_mem[r_tx_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && rx_we) begin
            r_rx_mem[r_rx_wr] <= i_s_tdata;
        end
        if (s_accept) begin
            r_rx_q <= r_rx_mem[r_rx_rd];
        end
    end

    always_comb begin
        priority if (r_s1.use_tx) begin
            dout = r_tx_q;
        end else if (r_s1.use_rx) begin
            dout = r_rx_q;
        end else begin
            dout = '0;
        end
        n_m_tdata = {r_s1.overwrote, r_done_armed, r_empty_armed,
                     utrf_pkg::LEVEL_W'(r_rx_fill), utrf_pkg::LEVEL_W'(r_tx_fill),
                     !r_sending, r_s1.line_valid, dout, r_s1.ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_wr       <= '0;
            r_tx_rd       <= '0;
            r_tx_fill     <= '0;
            r_rx_wr       <= '0;
            r_rx_rd       <= '0;
            r_rx_fill     <= '0;
            r_empty_armed <= 1'b0;
            r_done_armed  <= 1'b0;
            r_sending     <= 1'b0;
            r_s1_valid    <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            if (s_accept) begin
                r_tx_wr       <= n_tx_wr;
                r_tx_rd       <= n_tx_rd;
                r_tx_fill     <= n_tx_fill;
                r_rx_wr       <= n_rx_wr;
                r_rx_rd       <= n_rx_rd;
                r_rx_fill     <= n_rx_fill;
                r_empty_armed <= n_empty_armed;
                r_done_armed  <= n_done_armed;
                r_sending     <= n_sending;
            end
            r_s1_valid <= s_accept;
            if (r_s1_valid) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1 <= n_s1;
        end
        if (r_s1_valid) begin
            r_m_tdata <= n_m_tdata;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;

`ifndef SYNTHESIS
    a_tx_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_fill <= utrf_pkg::TX_FW'(utrf_pkg::TX_DEPTH))
        else $error("Transmit fill count exceeds the ring depth.");

    a_stage_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s1_valid && r_m_valid))
        else $error("A staged result found the output register occupied.");

    a_pop_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && mode == utrf_pkg::MODE_POP_RX && !rx_empty)
        |=> (r_rx_fill == $past(r_rx_fill) - 1'b1))
        else $error("A successful pop did not lower the receive fill count.");

    a_line_needs_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && n_s1.line_valid) |-> (r_empty_armed || r_done_armed))
        else $error("A byte went to the line with no event armed.");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_uart_tx_rx_ring_fifo.sv -----
// ----------------------------------------------------------------------------
// tb_uart_tx_rx_ring_fifo
// Self-checking testbench for the serial ring buffer. Requests go in on the
// slave stream and each one is predicted by a behavioral model of both rings,
// the arm bits and the sending flag. Every status word on the master stream
// is compared field by field with the oldest prediction. Directed tests cover
// the corner cases and a long receiver hold-off, then random traffic runs
// under changing idle patterns.
// ----------------------------------------------------------------------------

module tb_uart_tx_rx_ring_fifo;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic                         overwrote;
        logic                         done_armed;
        logic                         empty_armed;
        logic [utrf_pkg::LEVEL_W-1:0] rx_level;
        logic [utrf_pkg::LEVEL_W-1:0] tx_level;
        logic                         tx_idle;
        logic                         line_valid;
        logic [utrf_pkg::BYTE_W-1:0]  data_out;
        logic                         ok;
    } t_uart_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;   // data[7:0]
    logic [2:0]  i_s_tuser = '0;   // mode[2:0]
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // ok[0], data_out[8:1], line_byte_valid[9], tx_idle[10], tx_level[19:11],
    // rx_level[28:20], empty_event_armed[29], complete_event_armed[30],
    // rx_overwrote[31]
    logic [31:0] o_m_tdata;

    uart_tx_rx_ring_fifo uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Ring model state.
    logic [utrf_pkg::BYTE_W-1:0] tx_ring_m [utrf_pkg::TX_DEPTH];
    logic [utrf_pkg::BYTE_W-1:0] rx_ring_m [utrf_pkg::RX_DEPTH];
    logic [utrf_pkg::TX_AW-1:0]  tx_wr_m, tx_rd_m;
    logic [utrf_pkg::RX_AW-1:0]  rx_wr_m, rx_rd_m;
    logic [utrf_pkg::TX_FW-1:0]  tx_fill_m;
    logic [utrf_pkg::RX_FW-1:0]  rx_fill_m;
    logic                        empty_arm_m, done_arm_m, sending_m;

    t_uart_status pending_status[$];

    int tx_gap_pct = 0;
    int rx_gap_pct = 0;
    logic hold_req = 1'b0;
    int items_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int stall_cycles = 0;
    int line_bytes_seen = 0;
    int overwrites_seen = 0;
    int cycle_count = 0;

    function automatic logic [utrf_pkg::BYTE_W-1:0] take_tx_byte();
        logic [utrf_pkg::BYTE_W-1:0] b;
        b = tx_ring_m[tx_rd_m];
        tx_rd_m = (tx_rd_m == utrf_pkg::TX_AW'(utrf_pkg::TX_DEPTH - 1)) ?
                  '0 : tx_rd_m + 1'b1;
        tx_fill_m = tx_fill_m - 1'b1;
        return b;
    endfunction

    function automatic t_uart_status predict_status(utrf_pkg::t_mode m, logic [7:0] d,
                                                    logic l);
        t_uart_status s;
        s = '0;
        case (m)
            utrf_pkg::MODE_PUSH_TX: begin
                if (tx_fill_m < utrf_pkg::TX_FW'(utrf_pkg::TX_DEPTH)) begin
                    tx_ring_m[tx_wr_m] = d;
                    tx_wr_m = (tx_wr_m == utrf_pkg::TX_AW'(utrf_pkg::TX_DEPTH - 1)) ?
                              '0 : tx_wr_m + 1'b1;
                    tx_fill_m = tx_fill_m + 1'b1;
                    s.ok = 1'b1;
                    if (l) begin
                        empty_arm_m = 1'b1;
                    end
                end else begin
                    empty_arm_m = 1'b1;
                end
            end
            utrf_pkg::MODE_POP_RX: begin
                if (rx_fill_m != 0) begin
                    s.data_out = rx_ring_m[rx_rd_m];
                    rx_rd_m = (rx_rd_m == utrf_pkg::RX_AW'(utrf_pkg::RX_DEPTH - 1)) ?
                              '0 : rx_rd_m + 1'b1;
                    rx_fill_m = rx_fill_m - 1'b1;
                    s.ok = 1'b1;
                end
            end
            utrf_pkg::MODE_LINE_IN: begin
                rx_ring_m[rx_wr_m] = d;
                rx_wr_m = (rx_wr_m == utrf_pkg::RX_AW'(utrf_pkg::RX_DEPTH - 1)) ?
                          '0 : rx_wr_m + 1'b1;
                if (rx_fill_m < utrf_pkg::RX_FW'(utrf_pkg::RX_DEPTH)) begin
                    rx_fill_m = rx_fill_m + 1'b1;
                end else begin
                    s.overwrote = 1'b1;
                end
            end
            utrf_pkg::MODE_TX_EMPTY: begin
                if (empty_arm_m) begin
                    if (tx_fill_m == 0) begin
                        empty_arm_m = 1'b0;
                        done_arm_m = 1'b1;
                    end else begin
                        sending_m = 1'b1;
                        s.data_out = take_tx_byte();
                        s.line_valid = 1'b1;
                    end
                end
            end
            utrf_pkg::MODE_TX_DONE: begin
                if (done_arm_m) begin
                    if (tx_fill_m == 0) begin
                        done_arm_m = 1'b0;
                        sending_m = 1'b0;
                    end else begin
                        s.data_out = take_tx_byte();
                        s.line_valid = 1'b1;
                    end
                end
            end
            utrf_pkg::MODE_CLEAR_TX: begin
                tx_wr_m = '0;
                tx_rd_m = '0;
                tx_fill_m = '0;
            end
            utrf_pkg::MODE_CLEAR_RX: begin
                rx_wr_m = '0;
                rx_rd_m = '0;
                rx_fill_m = '0;
            end
            default: begin
            end
        endcase
        s.tx_idle = !sending_m;
        s.tx_level = utrf_pkg::LEVEL_W'(tx_fill_m);
        s.rx_level = utrf_pkg::LEVEL_W'(rx_fill_m);
        s.empty_armed = empty_arm_m;
        s.done_armed = done_arm_m;
        return s;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    task automatic send_req(input utrf_pkg::t_mode m, input logic [7:0] d, input logic l);
        while ($urandom_range(99) < tx_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= d;
        i_s_tuser <= m;
        i_s_tlast <= l;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        pending_status.push_back(predict_status(m, d, l));
        items_sent++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_status.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Receiver side: random stalls, or a long hold-off when requested.
    always @(posedge i_clk) begin : sink_ready
        int hold_left;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_left <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_gap_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_uart_status act, exp_s;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            act = t_uart_status'(o_m_tdata);
            if (pending_status.size() == 0) begin
                $error("status word 0x%08h arrived with no request pending", o_m_tdata);
                mismatches++;
            end else begin
                exp_s = pending_status.pop_front();
                check_field("ok", exp_s.ok, act.ok);
                check_field("data_out", exp_s.data_out, act.data_out);
                check_field("line_byte_valid", exp_s.line_valid, act.line_valid);
                check_field("tx_idle", exp_s.tx_idle, act.tx_idle);
                check_field("tx_level", exp_s.tx_level, act.tx_level);
                check_field("rx_level", exp_s.rx_level, act.rx_level);
                check_field("empty_event_armed", exp_s.empty_armed, act.empty_armed);
                check_field("complete_event_armed", exp_s.done_armed, act.done_armed);
                check_field("rx_overwrote", exp_s.overwrote, act.overwrote);
                results_checked++;
                if (exp_s.line_valid) begin
                    line_bytes_seen++;
                end
                if (exp_s.overwrote) begin
                    overwrites_seen++;
                end
            end
        end
        if (i_s_tvalid && !o_s_tready) begin
            stall_cycles++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_idle_ops();
        send_req(utrf_pkg::MODE_POP_RX, 8'h00, 1'b0);
        send_req(utrf_pkg::MODE_TX_EMPTY, 8'hFF, 1'b1);
        send_req(utrf_pkg::MODE_TX_DONE, 8'h00, 1'b0);
        send_req(utrf_pkg::MODE_NOP, 8'hFF, 1'b1);
        send_req(utrf_pkg::MODE_CLEAR_TX, 8'h00, 1'b0);
        send_req(utrf_pkg::MODE_CLEAR_RX, 8'h00, 1'b0);
        wait_drained();
    endtask

    task automatic test_tx_message();
        send_req(utrf_pkg::MODE_PUSH_TX, 8'h00, 1'b0);
        send_req(utrf_pkg::MODE_PUSH_TX, 8'hFF, 1'b0);
        send_req(utrf_pkg::MODE_PUSH_TX, 8'hA5, 1'b1);
        repeat (4) send_req(utrf_pkg::MODE_TX_EMPTY, 8'h00, 1'b0);
        send_req(utrf_pkg::MODE_TX_DONE, 8'h00, 1'b0);
        // The complete event drains bytes queued after the empty event disarmed.
        send_req(utrf_pkg::MODE_PUSH_TX, 8'h3C, 1'b1);
        send_req(utrf_pkg::MODE_TX_EMPTY, 8'h00, 1'b0);
        send_req(utrf_pkg::MODE_TX_EMPTY, 8'h00, 1'b0);
        send_req(utrf_pkg::MODE_PUSH_TX, 8'hC3, 1'b0);
        send_req(utrf_pkg::MODE_PUSH_TX, 8'h5A, 1'b0);
        repeat (3) send_req(utrf_pkg::MODE_TX_DONE, 8'h00, 1'b0);
        // Clearing the ring leaves the arm bits alone.
        send_req(utrf_pkg::MODE_PUSH_TX, 8'h11, 1'b1);
        send_req(utrf_pkg::MODE_CLEAR_TX, 8'h00, 1'b0);
        send_req(utrf_pkg::MODE_TX_EMPTY, 8'h00, 1'b0);
        send_req(utrf_pkg::MODE_TX_DONE, 8'h00, 1'b0);
        wait_drained();
    endtask

    task automatic test_rx_path();
        send_req(utrf_pkg::MODE_LINE_IN, 8'h00, 1'b0);
        send_req(utrf_pkg::MODE_LINE_IN, 8'hFF, 1'b1);
        repeat (3) send_req(utrf_pkg::MODE_POP_RX, 8'h00, 1'b0);
        send_req(utrf_pkg::MODE_LINE_IN, 8'h12, 1'b0);
        send_req(utrf_pkg::MODE_CLEAR_RX, 8'h00, 1'b0);
        send_req(utrf_pkg::MODE_POP_RX, 8'h00, 1'b0);
        wait_drained();
    endtask

    task automatic test_full_rings();
        repeat (utrf_pkg::TX_DEPTH) send_req(utrf_pkg::MODE_PUSH_TX, 8'($urandom), 1'b0);
        send_req(utrf_pkg::MODE_PUSH_TX, 8'($urandom), 1'b0);
        repeat (3) send_req(utrf_pkg::MODE_TX_EMPTY, 8'($urandom), 1'($urandom));
        send_req(utrf_pkg::MODE_PUSH_TX, 8'($urandom), 1'b1);
        send_req(utrf_pkg::MODE_CLEAR_TX, 8'h00, 1'b0);
        send_req(utrf_pkg::MODE_TX_EMPTY, 8'h00, 1'b0);
        send_req(utrf_pkg::MODE_TX_DONE, 8'h00, 1'b0);
        repeat (utrf_pkg::RX_DEPTH + 3) begin
            send_req(utrf_pkg::MODE_LINE_IN, 8'($urandom), 1'($urandom));
        end
        repeat (4) send_req(utrf_pkg::MODE_POP_RX, 8'($urandom), 1'($urandom));
        send_req(utrf_pkg::MODE_CLEAR_RX, 8'h00, 1'b0);
        send_req(utrf_pkg::MODE_POP_RX, 8'h00, 1'b0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        repeat (10) begin
            send_req(utrf_pkg::MODE_LINE_IN, 8'($urandom), 1'($urandom));
            send_req(utrf_pkg::MODE_POP_RX, 8'($urandom), 1'($urandom));
        end
        wait_drained();
    endtask

    task automatic run_traffic(input int n_items);
        int stop_at, len, pick;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    send_req(utrf_pkg::MODE_PUSH_TX, 8'($urandom), k == len - 1);
                end
                repeat ($urandom_range(len, len + 2)) begin
                    send_req(utrf_pkg::MODE_TX_EMPTY, 8'($urandom), 1'b0);
                end
                repeat ($urandom_range(1, 2)) begin
                    send_req(utrf_pkg::MODE_TX_DONE, 8'($urandom), 1'b0);
                end
            end else if (pick < 70) begin
                len = $urandom_range(1, 10);
                repeat (len) send_req(utrf_pkg::MODE_LINE_IN, 8'($urandom), 1'($urandom));
                repeat ($urandom_range(len, len + 2)) begin
                    send_req(utrf_pkg::MODE_POP_RX, 8'($urandom), 1'b0);
                end
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4)) begin
                    send_req(utrf_pkg::MODE_PUSH_TX, 8'($urandom), 1'b0);
                end
                repeat ($urandom_range(1, 5)) begin
                    send_req(utrf_pkg::MODE_TX_DONE, 8'($urandom), 1'b0);
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_req(utrf_pkg::t_mode'(3'($urandom_range(7))), 8'($urandom),
                             1'($urandom));
                end
            end
        end
        wait_drained();
    endtask

    initial begin
        tx_wr_m = '0;
        tx_rd_m = '0;
        tx_fill_m = '0;
        rx_wr_m = '0;
        rx_rd_m = '0;
        rx_fill_m = '0;
        empty_arm_m = 1'b0;
        done_arm_m = 1'b0;
        sending_m = 1'b0;
        tx_gap_pct = 23;
        rx_gap_pct = 84;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_ops();
        test_tx_message();
        test_rx_path();
        test_full_rings();
        test_backpressure();

        run_traffic(40);
        tx_gap_pct = 84;
        rx_gap_pct = 23;
        run_traffic(40);
        tx_gap_pct = 0;
        rx_gap_pct = 0;
        run_traffic(40);

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d requests and %0d status words, %0d bytes to the line.",
                 items_sent, results_checked, line_bytes_seen);
        $display("Full-ring overwrites: %0d, input stall cycles: %0d, mismatches: %0d.",
                 overwrites_seen, stall_cycles, mismatches);
        if (mismatches == 0 && pending_status.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/utrf_pkg.sv
hdl/uart_tx_rx_ring_fifo.sv
sim/tb_uart_tx_rx_ring_fifo.sv
